### hw/rtl/transient_peak_decay_meter_macros.svh
// ----------------------------------------------------------------------------
// transient peak decay meter assertion macros
// shared property forms for the checker of the meter
// ----------------------------------------------------------------------------
`ifndef TRANSIENT_PEAK_DECAY_METER_MACROS_SVH
`define TRANSIENT_PEAK_DECAY_METER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define TPDM_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define TPDM_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### hw/rtl/tpdm_pkg.sv
// ----------------------------------------------------------------------------
// tpdm_pkg
// types and constants shared by the transient peak decay meter
// ----------------------------------------------------------------------------
package tpdm_pkg;

	localparam int LVL_W  = 32;
	localparam int AMP_W  = 33;
	localparam int TIME_W = 48;

	// packed stream widths, padded to whole bytes
	localparam int IN_BITS  = 1 + 2 * LVL_W + TIME_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 2 * LVL_W + AMP_W + 2 * TIME_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// measurement phase
	typedef enum logic [1:0] {
		PH_ARMED = 2'd0,
		PH_PEAK  = 2'd1,
		PH_DONE  = 2'd2
	} phase_t;

	// one input sample
	typedef struct packed {
		logic                     stim_active;
		logic signed [LVL_W-1:0]  level;
		logic signed [LVL_W-1:0]  slope;
		logic        [TIME_W-1:0] timestamp;
	} tpdm_sample_t;

	// measurement state, the held measures double as the result
	typedef struct packed {
		phase_t                   phase;
		logic                     stim_was_active;
		logic signed [LVL_W-1:0]  prev_level;
		logic signed [LVL_W-1:0]  prev_slope;
		logic signed [LVL_W-1:0]  rest_reg;
		logic signed [LVL_W-1:0]  peak_reg;
		logic signed [AMP_W-1:0]  amp_reg;
		logic        [TIME_W-1:0] onset_time;
		logic        [TIME_W-1:0] peak_time;
		logic        [TIME_W-1:0] ttp_reg;
		logic        [TIME_W-1:0] decay_reg;
	} tpdm_state_t;

endpackage

### hw/rtl/tpdm_step.sv
// ----------------------------------------------------------------------------
// tpdm_step
// next-state logic of the meter for one sample: onset, peak, half decay
// ----------------------------------------------------------------------------
module tpdm_step (
	input  tpdm_pkg::tpdm_state_t  st,
	input  tpdm_pkg::tpdm_sample_t smp,
	output tpdm_pkg::tpdm_state_t  st_next
);
	import tpdm_pkg::*;

	logic                     onset;
	phase_t                   phase_a;
	phase_t                   phase_b;
	logic signed [LVL_W-1:0]  rest_a;
	logic        [TIME_W-1:0] onset_a;
	logic                     turn;
	logic                     peak_hit;
	logic signed [LVL_W-1:0]  peak_b;
	logic        [TIME_W-1:0] peak_time_b;
	logic signed [LVL_W+1:0]  lvl_x2;
	logic signed [LVL_W+1:0]  half_sum;
	logic                     cross_hit;

	// rising edge of the stimulus re-arms and takes the rest level
	assign onset   = smp.stim_active && !st.stim_was_active;
	assign phase_a = onset ? PH_ARMED : st.phase;
	assign rest_a  = onset ? st.prev_level : st.rest_reg;
	assign onset_a = onset ? smp.timestamp : st.onset_time;

	// slope turns: zero now, or negative after a non-negative slope
	assign turn     = (smp.slope == '0) || (smp.slope[LVL_W-1] && !st.prev_slope[LVL_W-1]);
	assign peak_hit = (phase_a == PH_ARMED) && turn;

	assign peak_b      = peak_hit ? smp.level : st.peak_reg;
	assign peak_time_b = peak_hit ? smp.timestamp : st.peak_time;
	assign phase_b     = peak_hit ? PH_PEAK : phase_a;

	// half level test as 2*level <= peak + rest, exact
	assign lvl_x2    = {smp.level[LVL_W-1], smp.level, 1'b0};
	assign half_sum  = {{2{peak_b[LVL_W-1]}}, peak_b} + {{2{rest_a[LVL_W-1]}}, rest_a};
	assign cross_hit = (phase_b == PH_PEAK) && (lvl_x2 <= half_sum);

	// assemble the next state
	always_comb begin
		st_next                 = st;
		st_next.stim_was_active = smp.stim_active;
		st_next.prev_level      = smp.level;
		st_next.prev_slope      = smp.slope;
		st_next.rest_reg        = rest_a;
		st_next.onset_time      = onset_a;
		st_next.peak_reg        = peak_b;
		st_next.peak_time       = peak_time_b;
		st_next.phase           = cross_hit ? PH_DONE : phase_b;
		if (peak_hit) begin
			st_next.amp_reg = {smp.level[LVL_W-1], smp.level} - {rest_a[LVL_W-1], rest_a};
			st_next.ttp_reg = smp.timestamp - onset_a;
		end
		if (cross_hit) begin
			st_next.decay_reg = smp.timestamp - peak_time_b;
		end
	end

endmodule

### hw/rtl/transient_peak_decay_meter.sv
// ----------------------------------------------------------------------------
// transient_peak_decay_meter
// measures rest, peak, amplitude, time to peak and half-decay time of a transient
// ----------------------------------------------------------------------------
// One result item leaves for every sample item taken, one item per clock cycle
// sustained while the result is not stalled. An item passes an input
// register, then the onset, peak and half-level logic that updates the held
// measures, which are themselves the result register. The measures wait while
// the result is stalled, and a sample may sit in the input register meanwhile.
// Nothing is measured before the first stimulus onset; all measures read zero
// after reset.
module transient_peak_decay_meter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// stim_active, level, slope, timestamp, zero pad
	input  logic [tpdm_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// rest_level, peak_level, amplitude, time_to_peak, half_decay_time, zero pad
	output logic [tpdm_pkg::OUT_W-1:0]  m_axis_tdata
);
	import tpdm_pkg::*;

	logic          vld_s1;
	tpdm_sample_t  smp_s1;
	tpdm_sample_t  smp_in;
	tpdm_state_t   state_q;
	tpdm_state_t   state_next;
	logic          out_vld_q;
	logic          advance;

	// unpack the input item
	assign smp_in.stim_active = s_axis_tdata[0];
	assign smp_in.level       = s_axis_tdata[LVL_W:1];
	assign smp_in.slope       = s_axis_tdata[2*LVL_W:LVL_W+1];
	assign smp_in.timestamp   = s_axis_tdata[2*LVL_W+TIME_W:2*LVL_W+1];

	// flow control between input register and result
	assign advance       = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			smp_s1 <= smp_in;
		end
	end

	tpdm_step u_step (
		.st      (state_q),
		.smp     (smp_s1),
		.st_next (state_next)
	);

	// measurement state, updated as each item moves to the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= {PH_DONE, {($bits(tpdm_state_t)-2){1'b0}}};
			out_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (advance) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// pack the result item
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, state_q.decay_reg, state_q.ttp_reg,
		state_q.amp_reg, state_q.peak_reg, state_q.rest_reg};

endmodule

### hw/rtl/tpdm_checker.sv
// ----------------------------------------------------------------------------
// tpdm_checker
// port-level checks on the transient peak decay meter, bound to the top level
// ----------------------------------------------------------------------------
`include "transient_peak_decay_meter_macros.svh"

module tpdm_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [tpdm_pkg::OUT_W-1:0]  m_axis_tdata
);
	import tpdm_pkg::*;

	// stalled result holds
	`TPDM_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// with no pending result the input side is open
	`TPDM_ASSERT_SAME(a_ready, !m_axis_tvalid, s_axis_tready, "input blocked with no result pending")

	// an accepted input item has a result valid once it has passed the input register and the result register
	`TPDM_ASSERT_NEXT(a_latency, $past(s_axis_tvalid && s_axis_tready), m_axis_tvalid, "no result two cycles after an accepted item")

endmodule

bind transient_peak_decay_meter tpdm_checker u_tpdm_checker (.*);
